// ===== rtl/core/pipc_pkg.sv =====
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared types and constants for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pipc_pkg;

  // vertex count, saturating; zero means no polygon open
  typedef logic [1:0] cnt_t;

  localparam cnt_t CntIdle = 2'd0;
  localparam cnt_t CntOne  = 2'd1;
  localparam cnt_t CntSat  = 2'd3;

  // registered edge-test control
  typedef struct packed {
    logic straddle;  // edge spans the ray's line (one end above, one not)
    logic pos;       // start vertex of the edge lies above the point
  } edge_ctl_t;

endpackage

// ===== rtl/core/pipc_edge.sv =====
// ----------------------------------------------------------------------------
// pipc_edge
// One edge against the rightward ray: registers bx*ay and ax*by and the
// straddle flags, then compares the exact difference of the products.
// ----------------------------------------------------------------------------
module pipc_edge #(
  parameter int RelBits = 25
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      en_i,
  input  logic signed [RelBits-1:0] ax_i,
  input  logic signed [RelBits-1:0] ay_i,
  input  logic signed [RelBits-1:0] bx_i,
  input  logic signed [RelBits-1:0] by_i,
  output logic                      cross_o
);
  import pipc_pkg::*;

  localparam int ProdBits = 2 * RelBits;

  edge_ctl_t                  ctl_d, ctl_q;
  logic signed [ProdBits-1:0] p1_d, p1_q, p2_d, p2_q;
  logic        [ProdBits:0]   diff;
  logic                       ay_pos, by_pos;

  assign ay_pos = !ay_i[RelBits-1] && (|ay_i);
  assign by_pos = !by_i[RelBits-1] && (|by_i);

  assign ctl_d.straddle = en_i && (ay_pos != by_pos);
  assign ctl_d.pos      = ay_pos;
  assign p1_d           = bx_i * ay_i;
  assign p2_d           = ax_i * by_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  assign diff = {p1_q[ProdBits-1], p1_q} - {p2_q[ProdBits-1], p2_q};

  // crossing abscissa positive: numerator sign matches denominator sign
  assign cross_o = ctl_q.straddle &&
                   (ctl_q.pos ? (!diff[ProdBits] && (|diff)) : diff[ProdBits]);

endmodule

// ===== rtl/core/point_in_polygon_crossing_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Streamed crossing-number test of a query point against a closed polygon.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | point_x/y, vertex_x/y, first/last_vertex
//   out     | out_valid_o/out_stall_i | inside_res, on_vertex, too_few
//
// One vertex item per cycle unless in_stall_o is high. An accepted last item
// goes through relative vertex and products, then compare/result register.
// Input stalls only while a result sits stalled and another is ready behind it.
// Reset clears the count, parity, hit flag and all valid bits.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         first_vertex_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  output logic                         on_vertex_o,
  output logic                         too_few_o
);
  import pipc_pkg::*;

  localparam int RelBits = COORD_BITS + 1;

  logic adv;

  // input register
  logic                         s0_vld_q;
  logic signed [COORD_BITS-1:0] s0_px_q, s0_py_q, s0_vx_q, s0_vy_q;
  logic                         s0_first_q, s0_last_q;

  // relative vertex stage and polygon state
  logic                         start;
  logic signed [COORD_BITS-1:0] ptx, pty;
  logic signed [RelBits-1:0]    rx, ry, fx_sel, fy_sel;
  logic signed [COORD_BITS-1:0] held_x_q, held_y_q;
  logic signed [RelBits-1:0]    first_x_q, first_y_q, prev_x_q, prev_y_q;
  cnt_t                         cnt_q, cnt_inc, cnt_d;
  logic                         s1_vld_q, s1_start_q, s1_last_q, s1_few_q, s1_hit_q;
  logic                         cross1, cross2;

  // result stage
  logic cross_par_q, cross_par_d, hit_q, hit_d;
  logic out_load;

  assign adv        = !(out_valid_o && out_stall_i && s1_vld_q && s1_last_q);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_px_q    <= point_x_i;
      s0_py_q    <= point_y_i;
      s0_vx_q    <= vertex_x_i;
      s0_vy_q    <= vertex_y_i;
      s0_first_q <= first_vertex_i;
      s0_last_q  <= last_vertex_i;
    end
  end

  assign start  = s0_first_q || (cnt_q == CntIdle);
  assign ptx    = start ? s0_px_q : held_x_q;
  assign pty    = start ? s0_py_q : held_y_q;
  assign rx     = {s0_vx_q[COORD_BITS-1], s0_vx_q} - {ptx[COORD_BITS-1], ptx};
  assign ry     = {s0_vy_q[COORD_BITS-1], s0_vy_q} - {pty[COORD_BITS-1], pty};
  assign fx_sel = start ? rx : first_x_q;
  assign fy_sel = start ? ry : first_y_q;

  always_comb begin
    if (start) begin
      cnt_inc = CntOne;
    end else if (cnt_q == CntSat) begin
      cnt_inc = CntSat;
    end else begin
      cnt_inc = cnt_q + CntOne;
    end
    cnt_d = s0_last_q ? CntIdle : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= CntIdle;
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s0_vld_q;
      if (s0_vld_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_start_q <= start;
      s1_last_q  <= s0_last_q;
      s1_few_q   <= (cnt_inc != CntSat);
      s1_hit_q   <= (rx == '0) && (ry == '0);
      if (s0_vld_q) begin
        prev_x_q <= rx;
        prev_y_q <= ry;
        if (start) begin
          held_x_q  <= s0_px_q;
          held_y_q  <= s0_py_q;
          first_x_q <= rx;
          first_y_q <= ry;
        end
      end
    end
  end

  // edge from the previous vertex to this one
  pipc_edge #(.RelBits(RelBits)) u_edge_prev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .en_i    (s0_vld_q && !start),
    .ax_i    (prev_x_q),
    .ay_i    (prev_y_q),
    .bx_i    (rx),
    .by_i    (ry),
    .cross_o (cross1)
  );

  // closing edge back to the first vertex
  pipc_edge #(.RelBits(RelBits)) u_edge_close (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .en_i    (s0_vld_q && s0_last_q),
    .ax_i    (rx),
    .ay_i    (ry),
    .bx_i    (fx_sel),
    .by_i    (fy_sel),
    .cross_o (cross2)
  );

  assign cross_par_d = (s1_start_q ? 1'b0 : cross_par_q) ^ cross1 ^ cross2;
  assign hit_d       = (s1_start_q ? 1'b0 : hit_q) | s1_hit_q;
  assign out_load    = adv && s1_vld_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_par_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv && s1_vld_q) begin
        cross_par_q <= cross_par_d;
        hit_q       <= hit_d;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      inside_res_o <= !s1_few_q && !hit_d && cross_par_d;
      on_vertex_o  <= hit_d;
      too_few_o    <= s1_few_q;
    end
  end

  // inside excludes a vertex hit and a short polygon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(inside_res_o && (on_vertex_o || too_few_o)))
    else $error("inside reported with vertex hit or too few vertices");

  // input is held only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // an open polygon keeps a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_vld_q && !s0_last_q) |=> (cnt_q != CntIdle))
    else $error("count idle after a non-closing item");

  // a closing item returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_vld_q && s0_last_q) |=> (cnt_q == CntIdle))
    else $error("count not idle after a closing item");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the streamed point-in-polygon crossing test against a local
// predictor. Directed polygons cover the full-scale corners, a point on a
// vertex or an edge, one- and two-vertex polygons, a restart inside an open
// polygon and a polygon opened without a first mark. Random polygons follow,
// with both sides idling at random and one long output hold that backs up
// the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import pipc_pkg::*;

  localparam int CoordBits  = 24;
  localparam int ItemTarget = 1800;
  localparam int HoldLength = 300;
  localparam int CycleLimit = 400000;
  localparam int Drain      = 20;

  localparam logic signed [CoordBits-1:0] MaxCoord = 24'h7fffff;
  localparam logic signed [CoordBits-1:0] MinCoord = 24'h800000;

  typedef struct {
    bit in_poly;
    bit on_vertex;
    bit too_few;
  } verdict_t;

  // predictor of the crossing test plus queue of pending verdicts
  class polygon_board;
    logic signed [CoordBits-1:0] held_px, held_py;
    logic signed [CoordBits:0]   first_rx, first_ry, prev_rx, prev_ry;
    bit                          parity, hit;
    cnt_t                        count;
    verdict_t                    verdicts_due[$];
    int                          errors;

    function new();
      held_px  = '0;
      held_py  = '0;
      first_rx = '0;
      first_ry = '0;
      prev_rx  = '0;
      prev_ry  = '0;
      parity   = 1'b0;
      hit      = 1'b0;
      count    = CntIdle;
      errors   = 0;
    endfunction

    // edge a->b against the rightward ray, coordinates relative to the point
    function void cross_edge(logic signed [CoordBits:0] ax, ay, bx, by);
      longint diff;
      if ((by > 0) == (ay > 0)) return;
      diff = longint'(bx) * longint'(ay) - longint'(ax) * longint'(by);
      if ((ay > 0) ? (diff > 0) : (diff < 0)) parity = ~parity;
    endfunction

    function void note_vertex(logic signed [CoordBits-1:0] px, py, vx, vy,
                              logic first_mark, logic last_mark);
      bit                        start;
      logic signed [CoordBits:0] rx, ry;
      verdict_t                  v;
      start = first_mark || (count == CntIdle);
      if (start) begin
        held_px = px;
        held_py = py;
        parity  = 1'b0;
        hit     = 1'b0;
        count   = CntIdle;
      end
      rx = 25'(vx) - 25'(held_px);
      ry = 25'(vy) - 25'(held_py);
      if (rx == 0 && ry == 0) hit = 1'b1;
      if (start) begin
        first_rx = rx;
        first_ry = ry;
      end else begin
        cross_edge(prev_rx, prev_ry, rx, ry);
      end
      prev_rx = rx;
      prev_ry = ry;
      if (count != CntSat) count = count + CntOne;
      if (!last_mark) return;
      cross_edge(rx, ry, first_rx, first_ry);
      v.too_few   = (count != CntSat);
      v.on_vertex = hit;
      v.in_poly   = !v.too_few && !hit && parity;
      verdicts_due = {verdicts_due, v};
      count = CntIdle;
    endfunction

    function void check_verdict(logic in_poly, logic on_vertex, logic too_few);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result: inside_res %b on_vertex %b too_few %b",
                 $time, in_poly, on_vertex, too_few);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      if (in_poly !== v.in_poly) begin
        $display("%0t: inside_res expected %b actual %b", $time, v.in_poly, in_poly);
        errors++;
      end
      if (on_vertex !== v.on_vertex) begin
        $display("%0t: on_vertex expected %b actual %b", $time, v.on_vertex, on_vertex);
        errors++;
      end
      if (too_few !== v.too_few) begin
        $display("%0t: too_few expected %b actual %b", $time, v.too_few, too_few);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic signed [CoordBits-1:0] point_x_i      = '0;
  logic signed [CoordBits-1:0] point_y_i      = '0;
  logic signed [CoordBits-1:0] vertex_x_i     = '0;
  logic signed [CoordBits-1:0] vertex_y_i     = '0;
  logic                        first_vertex_i = 1'b0;
  logic                        last_vertex_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic                        inside_res_o;
  logic                        on_vertex_o;
  logic                        too_few_o;

  polygon_board board;
  bit           calm      = 1'b0;
  bit           hold_req  = 1'b0;
  int           items_sent = 0;
  int           cycles    = 0;

  point_in_polygon_crossing_test #(
    .COORD_BITS(CoordBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .on_vertex_o    (on_vertex_o),
    .too_few_o      (too_few_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_vertex(point_x_i, point_y_i, vertex_x_i, vertex_y_i,
                        first_vertex_i, last_vertex_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_verdict(inside_res_o, on_vertex_o, too_few_o);
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int hold_cycles;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HoldLength; hold_cycles++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 32) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic signed [CoordBits-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[CoordBits-1:0];
  endfunction

  function automatic logic signed [CoordBits-1:0] pick_extreme(logic signed [CoordBits-1:0] p);
    case ($urandom_range(0, 4))
      0:       return MinCoord;
      1:       return MaxCoord;
      2:       return '0;
      3:       return '1;
      default: return p;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_vertex(logic signed [CoordBits-1:0] px, py, vx, vy,
                             logic first_mark, logic last_mark);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    point_x_i      <= px;
    point_y_i      <= py;
    vertex_x_i     <= vx;
    vertex_y_i     <= vy;
    first_vertex_i <= first_mark;
    last_vertex_i  <= last_mark;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  initial begin
    int                          polys;
    int                          kind;
    int                          shape;
    int                          n;
    int                          k;
    int                          a, b, c, d;
    bit                          mark;
    logic signed [CoordBits-1:0] px, py, vx, vy;

    board = new();
    polys = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // opened from idle without a first mark
    send_vertex(0, 0, -10, -10, 1'b0, 1'b0);
    send_vertex(0, 0,  10, -10, 1'b0, 1'b0);
    send_vertex(0, 0,  10,  10, 1'b0, 1'b0);
    send_vertex(0, 0, -10,  10, 1'b0, 1'b1);
    // full-scale square
    send_vertex(0, 0, MinCoord, MinCoord, 1'b1, 1'b0);
    send_vertex(0, 0, MaxCoord, MinCoord, 1'b0, 1'b0);
    send_vertex(0, 0, MaxCoord, MaxCoord, 1'b0, 1'b0);
    send_vertex(0, 0, MinCoord, MaxCoord, 1'b0, 1'b1);
    // point on a full-scale corner
    send_vertex(MaxCoord, MaxCoord, MinCoord, MinCoord, 1'b1, 1'b0);
    send_vertex(MaxCoord, MaxCoord, MaxCoord, MinCoord, 1'b0, 1'b0);
    send_vertex(MaxCoord, MaxCoord, MaxCoord, MaxCoord, 1'b0, 1'b1);
    // point at the negative corner, vertices far away
    send_vertex(MinCoord, MinCoord, MaxCoord, MaxCoord, 1'b1, 1'b0);
    send_vertex(MinCoord, MinCoord, MinCoord, MaxCoord, 1'b0, 1'b0);
    send_vertex(MinCoord, MinCoord, MaxCoord, MinCoord, 1'b0, 1'b1);
    // single vertex on the point
    send_vertex(7, -7, 7, -7, 1'b1, 1'b1);
    // two vertices
    send_vertex(0, 0, -3,  5, 1'b1, 1'b0);
    send_vertex(0, 0,  3, -5, 1'b0, 1'b1);
    // restart inside an open polygon
    send_vertex(0, 0, 100, 100, 1'b1, 1'b0);
    send_vertex(1, 1,  -5,  -5, 1'b1, 1'b0);
    send_vertex(1, 1,   8,  -2, 1'b0, 1'b0);
    send_vertex(1, 1,   0,   9, 1'b0, 1'b1);
    // point on an edge
    send_vertex(0, 0, -5, 0, 1'b1, 1'b0);
    send_vertex(0, 0,  5, 0, 1'b0, 1'b0);
    send_vertex(0, 0,  0, 5, 1'b0, 1'b1);

    while (items_sent < ItemTarget) begin
      polys++;
      calm = (polys >= 120 && polys < 180);
      if (polys == 250) begin
        // long output hold while single-vertex polygons keep coming
        hold_req = 1'b1;
        repeat (40) send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                1'b1, 1'b1);
      end
      kind = $urandom_range(0, 99);
      px   = rand_coord();
      py   = rand_coord();
      if (kind < 80) begin
        shape = $urandom_range(0, 3);
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        if (shape == 3) n = 4;
        mark  = ($urandom_range(0, 9) != 0);
        a     = $urandom_range(1, 1000);
        b     = $urandom_range(1, 1000);
        c     = $urandom_range(1, 1000);
        d     = $urandom_range(1, 1000);
        for (k = 0; k < n; k++) begin
          case (shape)
            0: begin
              vx = px + 24'($urandom_range(0, 8)) - 24'd4;
              vy = py + 24'($urandom_range(0, 8)) - 24'd4;
            end
            1: begin
              vx = rand_coord();
              vy = rand_coord();
            end
            2: begin
              vx = pick_extreme(px);
              vy = pick_extreme(py);
            end
            default: begin
              vx = (k == 0 || k == 3) ? px - 24'(a) : px + 24'(c);
              vy = (k < 2) ? py - 24'(b) : py + 24'(d);
            end
          endcase
          send_vertex(px, py, vx, vy, (k == 0) ? mark : 1'b0, k == n - 1);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 20);
        end
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pipc_pkg.sv
rtl/core/pipc_edge.sv
rtl/core/point_in_polygon_crossing_test.sv
test/tb_top.sv
